// File: design/sacl_pkg.sv
`timescale 1ns / 1ps

package sacl_pkg;

   localparam int MAX_SETS_DEF = 256;
   localparam int MAX_WAYS_DEF = 4;
   localparam int ADDR_BITS    = 32;

   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int TIME_W     = 31;
   localparam int KIND_W     = 3;
   localparam int OFFS_W     = 4;
   localparam int IDX_W      = 4;
   localparam int WAYB_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int SHIFT_W    = 5;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FILL   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TOUCH  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INVAL  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DIRTY  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAY_BITS    = 2'd2;

   localparam logic [OFFS_W-1:0] OFFSET_BITS_RST = 4'd6;
   localparam logic [IDX_W-1:0]  INDEX_BITS_RST  = 4'd8;
   localparam logic [WAYB_W-1:0] WAY_BITS_RST    = 2'd2;

   function automatic logic [ADDR_W-1:0] addr_mask(input int bits);
      logic [ADDR_W-1:0] m;
      m = '1;
      if (bits < ADDR_W) begin
         m = (ADDR_W'(1) << bits) - ADDR_W'(1);
      end
      return m;
   endfunction

   localparam logic [ADDR_W-1:0] ADDR_MASK = addr_mask(ADDR_BITS);

   // largest b below 16 with 2**b <= n, else 0
   function automatic int floor_log2(input int n);
      int r;
      r = 0;
      for (int i = 1; i < 16; i++) begin
         if ((1 << i) <= n) begin
            r = i;
         end
      end
      return r;
   endfunction

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic clear_we;
      logic rd_en;
      logic scan_en;
      logic scan_first;
      logic wb_en;
   } ctrl_type;

endpackage

// File: design/sacl_req_if.sv
`timescale 1ns / 1ps

interface sacl_req_if;
   logic                             valid;
   logic                             ready;
   logic [sacl_pkg::KIND_W-1:0]      kind;
   logic [sacl_pkg::ADDR_W-1:0]      address;
   logic [sacl_pkg::TIME_W-1:0]      time_req;

   modport source (output valid, kind, address, time_req, input ready);
   modport sink   (input valid, kind, address, time_req, output ready);
endinterface

// File: design/sacl_rsp_if.sv
`timescale 1ns / 1ps

interface sacl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic                             evicted;
   logic [sacl_pkg::ADDR_W-1:0]      evicted_address;
   logic                             evicted_dirty;

   modport source (output valid, hit, evicted, evicted_address, evicted_dirty, input ready);
   modport sink   (input valid, hit, evicted, evicted_address, evicted_dirty, output ready);
endinterface

// File: design/set_assoc_cache_tag_store_lru.sv
// channel | dir | handshake      | beat
// req     | in  | valid / ready  | kind, address, time_req
// rsp     | out | valid / ready  | hit, evicted, evicted_address, evicted_dirty
// csr     | in  | csr_write_en   | csr_index, csr_data (no read-back)
//
// An item goes through accept, set row read, one way per cycle through the shared
// compare unit over the N ways in use, and row write-back.
// After reset a clearing pass writes every set row, with req.ready low.
// The result sits in an output register; a new beat is taken while it waits,
// and write-back stalls only if the previous result is still not taken.
`timescale 1ns / 1ps

module set_assoc_cache_tag_store_lru #(
   parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF,
   parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   sacl_req_if.sink                            req,
   sacl_rsp_if.source                          rsp,
   input  logic                                csr_write_en,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SET_LOG = sacl_pkg::floor_log2(MAX_SETS);
   localparam int WAY_LOG = sacl_pkg::floor_log2(MAX_WAYS);
   localparam int TAG_W   = sacl_pkg::TAG_W;
   localparam int TIME_W  = sacl_pkg::TIME_W;
   localparam int ADDR_W  = sacl_pkg::ADDR_W;
   localparam int ROW_W   = MAX_WAYS * (2 + TAG_W + TIME_W);

   // configuration
   logic [sacl_pkg::OFFS_W-1:0] offset_bits_ff;
   logic [sacl_pkg::IDX_W-1:0]  index_bits_ff;
   logic [sacl_pkg::WAYB_W-1:0] way_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= sacl_pkg::OFFSET_BITS_RST;
         index_bits_ff  <= sacl_pkg::INDEX_BITS_RST;
         way_bits_ff    <= sacl_pkg::WAY_BITS_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            sacl_pkg::CSR_OFFSET_BITS: offset_bits_ff <= csr_data;
            sacl_pkg::CSR_INDEX_BITS:  index_bits_ff  <= csr_data;
            sacl_pkg::CSR_WAY_BITS:    way_bits_ff    <= csr_data[sacl_pkg::WAYB_W-1:0];
            default: ;
         endcase
      end
   end

   // request register
   logic [sacl_pkg::KIND_W-1:0] kind_ff;
   logic [ADDR_W-1:0]           addr_ff;
   logic [TIME_W-1:0]           time_ff;
   logic                        req_fire;

   assign req_fire = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req.kind;
         addr_ff <= req.address;
         time_ff <= req.time_req;
      end
   end

   // address split
   logic [sacl_pkg::IDX_W-1:0]   ib;
   logic [sacl_pkg::WAYB_W:0]    wb;
   logic [WAY_W-1:0]             last_way;
   logic [sacl_pkg::SHIFT_W-1:0] tag_shift;
   logic [ADDR_W-1:0]            addr_m;
   logic [ADDR_W-1:0]            set_full;
   logic [SET_W-1:0]             set_cur;
   logic [TAG_W-1:0]             tag_cur;

   always_comb begin
      ib = (index_bits_ff > sacl_pkg::IDX_W'(SET_LOG)) ? sacl_pkg::IDX_W'(SET_LOG)
                                                       : index_bits_ff;
      wb = ({1'b0, way_bits_ff} > (sacl_pkg::WAYB_W + 1)'(WAY_LOG))
           ? (sacl_pkg::WAYB_W + 1)'(WAY_LOG) : {1'b0, way_bits_ff};
      last_way  = WAY_W'((1 << wb) - 1);
      tag_shift = sacl_pkg::SHIFT_W'(offset_bits_ff) + sacl_pkg::SHIFT_W'(ib);
      addr_m    = addr_ff & sacl_pkg::ADDR_MASK;
      set_full  = (addr_m >> offset_bits_ff) & ((ADDR_W'(1) << ib) - ADDR_W'(1));
      set_cur   = set_full[SET_W-1:0];
      tag_cur   = TAG_W'(addr_m >> tag_shift);
   end

   // sequencer
   sacl_pkg::ctrl_type ctrl;
   logic [WAY_W-1:0]   way_idx;
   logic [SET_W-1:0]   clear_addr;
   logic               rsp_valid_ff;
   logic               rsp_busy;

   assign rsp_busy = rsp_valid_ff && !rsp.ready;

   sacl_ctrl #(
      .MAX_SETS (MAX_SETS),
      .MAX_WAYS (MAX_WAYS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .rsp_busy   (rsp_busy),
      .last_way   (last_way),
      .ctrl       (ctrl),
      .way_idx    (way_idx),
      .clear_addr (clear_addr),
      .req_ready  (req.ready)
   );

   // set row memory
   logic [ROW_W-1:0]                    rd_row;
   logic [ROW_W-1:0]                    wr_row;
   logic [MAX_WAYS-1:0]                 rd_valid, rd_dirty;
   logic [MAX_WAYS-1:0][TAG_W-1:0]      rd_tags;
   logic [MAX_WAYS-1:0][TIME_W-1:0]     rd_times;
   logic [MAX_WAYS-1:0]                 new_valid, new_dirty;
   logic [MAX_WAYS-1:0][TAG_W-1:0]      new_tags;
   logic [MAX_WAYS-1:0][TIME_W-1:0]     new_times;

   assign {rd_valid, rd_dirty, rd_tags, rd_times} = rd_row;
   assign wr_row = ctrl.clear_we ? '0 : {new_valid, new_dirty, new_tags, new_times};

   sacl_row_mem #(
      .DEPTH (MAX_SETS),
      .WIDTH (ROW_W)
   ) u_mem (
      .clock (clock),
      .we    (ctrl.clear_we || ctrl.wb_en),
      .waddr (ctrl.clear_we ? clear_addr : set_cur),
      .wdata (wr_row),
      .re    (ctrl.rd_en),
      .raddr (set_cur),
      .rdata (rd_row)
   );

   // way scan
   logic                hit_found, inv_found;
   logic [WAY_W-1:0]    hit_way, inv_way, min_way;
   logic [MAX_WAYS-1:0] match_mask;

   sacl_scan #(
      .MAX_WAYS (MAX_WAYS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .way_idx    (way_idx),
      .row_valid  (rd_valid),
      .row_tags   (rd_tags),
      .row_times  (rd_times),
      .key_tag    (tag_cur),
      .hit_found  (hit_found),
      .hit_way    (hit_way),
      .inv_found  (inv_found),
      .inv_way    (inv_way),
      .min_way    (min_way),
      .match_mask (match_mask)
   );

   // row update and result
   logic [WAY_W-1:0]  pick;
   logic              ev;
   logic              ev_dirty;
   logic [ADDR_W-1:0] ev_addr;

   always_comb begin
      pick      = inv_found ? inv_way : min_way;
      new_valid = rd_valid;
      new_dirty = rd_dirty;
      new_tags  = rd_tags;
      new_times = rd_times;
      ev        = 1'b0;
      ev_dirty  = 1'b0;
      ev_addr   = '0;
      case (kind_ff)
         sacl_pkg::KIND_FILL: begin
            new_tags[pick]  = tag_cur;
            new_valid[pick] = 1'b1;
            new_dirty[pick] = 1'b0;
            new_times[pick] = time_ff;
            if (!inv_found) begin
               ev       = 1'b1;
               ev_dirty = rd_dirty[pick];
               ev_addr  = (ADDR_W'(rd_tags[pick]) << tag_shift)
                          | (ADDR_W'(set_cur) << offset_bits_ff);
            end
         end
         sacl_pkg::KIND_TOUCH: begin
            if (hit_found) begin
               new_times[hit_way] = time_ff;
            end
         end
         sacl_pkg::KIND_INVAL: begin
            if (hit_found) begin
               new_valid[hit_way] = 1'b0;
            end
         end
         sacl_pkg::KIND_DIRTY: begin
            new_dirty = rd_dirty | match_mask;
         end
         default: ;
      endcase
   end

   logic              hit_ff, ev_ff, ev_dirty_ff;
   logic [ADDR_W-1:0] ev_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.wb_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wb_en) begin
         hit_ff      <= hit_found;
         ev_ff       <= ev;
         ev_dirty_ff <= ev_dirty;
         ev_addr_ff  <= ev_addr;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.hit             = hit_ff;
   assign rsp.evicted         = ev_ff;
   assign rsp.evicted_address = ev_addr_ff;
   assign rsp.evicted_dirty   = ev_dirty_ff;

endmodule

// File: design/sacl_row_mem.sv
`timescale 1ns / 1ps

module sacl_row_mem #(
   parameter int DEPTH = sacl_pkg::MAX_SETS_DEF,
   parameter int WIDTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/sacl_scan.sv
`timescale 1ns / 1ps

// One way per cycle while scan_en is set: tag compare, invalid search and oldest-timestamp search.
module sacl_scan #(
   parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  sacl_pkg::ctrl_type                           ctrl,
   input  logic [WAY_W-1:0]                             way_idx,
   input  logic [MAX_WAYS-1:0]                          row_valid,
   input  logic [MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0]     row_tags,
   input  logic [MAX_WAYS-1:0][sacl_pkg::TIME_W-1:0]    row_times,
   input  logic [sacl_pkg::TAG_W-1:0]                   key_tag,
   output logic                                         hit_found,
   output logic [WAY_W-1:0]                             hit_way,
   output logic                                         inv_found,
   output logic [WAY_W-1:0]                             inv_way,
   output logic [WAY_W-1:0]                             min_way,
   output logic [MAX_WAYS-1:0]                          match_mask
);

   logic                        hit_found_ff;
   logic [WAY_W-1:0]            hit_way_ff;
   logic                        inv_found_ff;
   logic [WAY_W-1:0]            inv_way_ff;
   logic [WAY_W-1:0]            min_way_ff;
   logic [sacl_pkg::TIME_W-1:0] min_time_ff;
   logic [MAX_WAYS-1:0]         mask_ff;

   logic                        cur_valid;
   logic                        cur_match;
   logic [sacl_pkg::TIME_W-1:0] cur_time;
   logic                        hit_prev;
   logic                        inv_prev;
   logic [MAX_WAYS-1:0]         mask_prev;
   logic                        older;

   always_comb begin
      cur_valid = row_valid[way_idx];
      cur_time  = row_times[way_idx];
      cur_match = cur_valid && (row_tags[way_idx] == key_tag);
      hit_prev  = ctrl.scan_first ? 1'b0 : hit_found_ff;
      inv_prev  = ctrl.scan_first ? 1'b0 : inv_found_ff;
      mask_prev = ctrl.scan_first ? '0 : mask_ff;
      // strict less keeps the lowest way on equal timestamps
      older     = ctrl.scan_first || (cur_time < min_time_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff <= 1'b0;
         inv_found_ff <= 1'b0;
         mask_ff      <= '0;
      end else if (ctrl.scan_en) begin
         hit_found_ff <= hit_prev | cur_match;
         inv_found_ff <= inv_prev | !cur_valid;
         mask_ff      <= mask_prev | (MAX_WAYS'(cur_match) << way_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scan_en) begin
         if (!hit_prev && cur_match) begin
            hit_way_ff <= way_idx;
         end
         if (!inv_prev && !cur_valid) begin
            inv_way_ff <= way_idx;
         end
         if (older) begin
            min_time_ff <= cur_time;
            min_way_ff  <= way_idx;
         end
      end
   end

   assign hit_found  = hit_found_ff;
   assign hit_way    = hit_way_ff;
   assign inv_found  = inv_found_ff;
   assign inv_way    = inv_way_ff;
   assign min_way    = min_way_ff;
   assign match_mask = mask_ff;

   a_hit_in_mask: assert property (@(posedge clock) disable iff (reset)
      hit_found_ff |-> mask_ff[hit_way_ff])
      else $error("first hit way not in match mask");

   a_hit_lowest: assert property (@(posedge clock) disable iff (reset)
      hit_found_ff |-> ((mask_ff & ((MAX_WAYS'(1) << hit_way_ff) - MAX_WAYS'(1))) == '0))
      else $error("match below the reported hit way");

   a_hit_mask_agree: assert property (@(posedge clock) disable iff (reset)
      hit_found_ff == (mask_ff != '0))
      else $error("hit flag and match mask disagree");

endmodule

// File: design/sacl_ctrl.sv
`timescale 1ns / 1ps

module sacl_ctrl #(
   parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF,
   parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
   localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               rsp_busy,
   input  logic [WAY_W-1:0]   last_way,
   output sacl_pkg::ctrl_type ctrl,
   output logic [WAY_W-1:0]   way_idx,
   output logic [SET_W-1:0]   clear_addr,
   output logic               req_ready
);

   sacl_pkg::state_type state_ff, state_in;
   logic [WAY_W-1:0]    way_ff, way_in;
   logic [SET_W-1:0]    clear_ff, clear_in;
   logic                clear_last;

   assign clear_last = (clear_ff == SET_W'(MAX_SETS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sacl_pkg::ST_SWEEP: begin
            if (clear_last) begin
               state_in = sacl_pkg::ST_IDLE;
            end
         end
         sacl_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = sacl_pkg::ST_READ;
            end
         end
         sacl_pkg::ST_READ: begin
            state_in = sacl_pkg::ST_SCAN;
         end
         sacl_pkg::ST_SCAN: begin
            if (way_ff == last_way) begin
               state_in = sacl_pkg::ST_WRITE;
            end
         end
         sacl_pkg::ST_WRITE: begin
            if (!rsp_busy) begin
               state_in = sacl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sacl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      way_in    = way_ff;
      clear_in  = clear_ff;
      case (state_ff)
         sacl_pkg::ST_SWEEP: begin
            ctrl.clear_we = 1'b1;
            clear_in      = clear_ff + SET_W'(1);
         end
         sacl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         sacl_pkg::ST_READ: begin
            ctrl.rd_en = 1'b1;
            way_in     = '0;
         end
         sacl_pkg::ST_SCAN: begin
            ctrl.scan_en    = 1'b1;
            ctrl.scan_first = (way_ff == '0);
            way_in          = way_ff + WAY_W'(1);
         end
         sacl_pkg::ST_WRITE: begin
            ctrl.wb_en = !rsp_busy;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacl_pkg::ST_SWEEP;
         way_ff   <= '0;
         clear_ff <= '0;
      end else begin
         state_ff <= state_in;
         way_ff   <= way_in;
         clear_ff <= clear_in;
      end
   end

   assign way_idx    = way_ff;
   assign clear_addr = clear_ff;

endmodule

// File: sim/tb_set_assoc_cache_tag_store_lru.sv
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_store_lru;

   localparam int          N_WAYS        = sacl_pkg::MAX_WAYS_DEF;
   localparam int          N_ENTRIES     = sacl_pkg::MAX_SETS_DEF * sacl_pkg::MAX_WAYS_DEF;
   localparam int          SET_LOG2_MAX  = 8;    // log2 MAX_SETS
   localparam int          WAY_LOG2_MAX  = 2;    // log2 MAX_WAYS
   localparam int          SETTLE_CYCLES = 16;
   localparam int          HOLD_CYCLES   = 400;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int          N_DIRECTED    = 26;
   localparam int          N_PHASES      = 7;
   localparam int          PHASE_BEATS   = 255;

   // kinds without a function of their own behave as lookup
   localparam logic [sacl_pkg::KIND_W-1:0] KIND_SPARE5 = 3'd5;
   localparam logic [sacl_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
   localparam logic [sacl_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;

   typedef struct packed {
      logic [sacl_pkg::KIND_W-1:0] kind;
      logic [sacl_pkg::ADDR_W-1:0] address;
      logic [sacl_pkg::TIME_W-1:0] time_req;
   } access_type;

   typedef struct packed {
      logic                        hit;
      logic                        evicted;
      logic [sacl_pkg::ADDR_W-1:0] evicted_address;
      logic                        evicted_dirty;
   } outcome_type;

   typedef struct packed {
      access_type  acc;
      logic        typed;
      outcome_type want;
   } directed_row_type;

   typedef struct packed {
      logic [sacl_pkg::OFFS_W-1:0] offs;
      logic [sacl_pkg::IDX_W-1:0]  idx;
      logic [sacl_pkg::WAYB_W-1:0] ways;
      logic [7:0]                  src_idle_pct;
      logic [7:0]                  sink_stall_pct;
   } geometry_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sacl_pkg::CSR_DATA_W-1:0] csr_data;

   sacl_req_if req_ch ();
   sacl_rsp_if rsp_ch ();

   set_assoc_cache_tag_store_lru DUT (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // shadow copy of the tag store and its geometry
   logic [sacl_pkg::TAG_W-1:0]  way_tag   [N_ENTRIES];
   logic                        way_valid [N_ENTRIES];
   logic                        way_dirty [N_ENTRIES];
   logic [sacl_pkg::TIME_W-1:0] way_stamp [N_ENTRIES];
   logic [sacl_pkg::OFFS_W-1:0] geo_offs;
   logic [sacl_pkg::IDX_W-1:0]  geo_idx;
   logic [sacl_pkg::WAYB_W-1:0] geo_ways;

   outcome_type pending_outcomes [$];
   int          mismatches;
   int          src_idle_pct;
   int          sink_stall_pct;
   logic        hold_request;
   int unsigned cycle_count;

   directed_row_type directed_rows [N_DIRECTED];
   geometry_type     phase_geo [N_PHASES];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic int set_log2();
      return (geo_idx > SET_LOG2_MAX) ? SET_LOG2_MAX : int'(geo_idx);
   endfunction

   function automatic int way_count();
      return 1 << ((geo_ways > WAY_LOG2_MAX) ? WAY_LOG2_MAX : int'(geo_ways));
   endfunction

   // one access against the shadow store; returns the outcome it produces
   function automatic outcome_type tag_store_step(input access_type acc);
      outcome_type                r;
      int                         ib;
      int                         nways;
      int                         base;
      int                         first;
      int                         pick;
      logic [31:0]                set_no;
      logic [sacl_pkg::TAG_W-1:0] tag;
      logic [63:0]                blk;
      ib     = set_log2();
      nways  = way_count();
      set_no = (acc.address >> geo_offs) & ((32'd1 << ib) - 32'd1);
      tag    = acc.address >> (int'(geo_offs) + ib);
      base   = int'(set_no) * N_WAYS;
      first  = -1;
      pick   = -1;
      r      = '0;
      for (int w = 0; w < nways; w++) begin
         if (first < 0 && way_valid[base + w] && way_tag[base + w] == tag) first = w;
      end
      r.hit = (first >= 0);
      if (acc.kind == sacl_pkg::KIND_FILL) begin
         for (int w = 0; w < nways; w++) begin
            if (pick < 0 && !way_valid[base + w]) pick = w;
         end
         if (pick < 0) begin
            pick = 0;
            for (int w = 1; w < nways; w++) begin
               if (way_stamp[base + w] < way_stamp[base + pick]) pick = w;
            end
            blk               = ((64'(way_tag[base + pick]) << ib) | 64'(set_no)) << geo_offs;
            r.evicted         = 1'b1;
            r.evicted_dirty   = way_dirty[base + pick];
            r.evicted_address = blk[31:0];
         end
         way_tag[base + pick]   = tag;
         way_valid[base + pick] = 1'b1;
         way_dirty[base + pick] = 1'b0;
         way_stamp[base + pick] = acc.time_req;
      end else if (first >= 0) begin
         case (acc.kind)
            sacl_pkg::KIND_TOUCH: way_stamp[base + first] = acc.time_req;
            sacl_pkg::KIND_INVAL: way_valid[base + first] = 1'b0;
            sacl_pkg::KIND_DIRTY: begin
               // every matching valid way, duplicates included
               for (int w = 0; w < nways; w++) begin
                  if (way_valid[base + w] && way_tag[base + w] == tag) way_dirty[base + w] = 1'b1;
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic access_type random_access();
      access_type  acc;
      int          roll;
      int          sh;
      logic [31:0] tagv;
      logic [31:0] setv;
      roll = $urandom_range(0, 99);
      if (roll < 30)      acc.kind = sacl_pkg::KIND_FILL;
      else if (roll < 45) acc.kind = sacl_pkg::KIND_LOOKUP;
      else if (roll < 62) acc.kind = sacl_pkg::KIND_TOUCH;
      else if (roll < 74) acc.kind = sacl_pkg::KIND_INVAL;
      else if (roll < 92) acc.kind = sacl_pkg::KIND_DIRTY;
      else                acc.kind = sacl_pkg::KIND_W'($urandom_range(5, 7));
      roll = $urandom_range(0, 9);
      if (roll < 6)       acc.time_req = sacl_pkg::TIME_W'($urandom_range(0, 15));
      else if (roll < 8)  acc.time_req = sacl_pkg::TIME_W'($urandom);
      else if (roll == 8) acc.time_req = '1;
      else                acc.time_req = '0;
      if ($urandom_range(0, 19) == 0) begin
         acc.address = $urandom;
      end else begin
         // few sets and few tags so that sets fill up and hits are common
         sh   = int'(geo_offs) + set_log2();
         setv = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 2));
         setv = setv & ((32'd1 << set_log2()) - 32'd1);
         tagv = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 1))
                                            : 32'($urandom_range(0, 5));
         acc.address = (tagv << sh) | (setv << geo_offs)
                     | (32'($urandom) & ((32'd1 << geo_offs) - 32'd1));
      end
      return acc;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 40) begin
         $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   task automatic offer_beat(input access_type acc, input logic typed,
                             input outcome_type typed_want);
      outcome_type predicted;
      if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= acc.kind;
      req_ch.address  <= acc.address;
      req_ch.time_req <= acc.time_req;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predicted = tag_store_step(acc);
      pending_outcomes.push_back(typed ? typed_want : predicted);
   endtask

   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_geometry(input geometry_type g);
      csr_write_en <= 1'b1;
      csr_index    <= sacl_pkg::CSR_OFFSET_BITS;
      csr_data     <= sacl_pkg::CSR_DATA_W'(g.offs);
      @(posedge clock);
      csr_index    <= sacl_pkg::CSR_INDEX_BITS;
      csr_data     <= sacl_pkg::CSR_DATA_W'(g.idx);
      @(posedge clock);
      csr_index    <= sacl_pkg::CSR_WAY_BITS;
      csr_data     <= sacl_pkg::CSR_DATA_W'(g.ways);
      @(posedge clock);
      csr_write_en <= 1'b0;
      geo_offs       = g.offs;
      geo_idx        = g.idx;
      geo_ways       = g.ways;
      src_idle_pct   = int'(g.src_idle_pct);
      sink_stall_pct = int'(g.sink_stall_pct);
   endtask

   // result side: random stalls, one long hold on request
   initial begin
      int          stall_left;
      int          hold_left;
      outcome_type got;
      outcome_type want;
      stall_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = '{rsp_ch.hit, rsp_ch.evicted, rsp_ch.evicted_address, rsp_ch.evicted_dirty};
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unexpected beat, hit/evicted", 32'({got.hit, got.evicted}), 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
               if (got.evicted !== want.evicted)
                  report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
               if (got.evicted_address !== want.evicted_address)
                  report_mismatch("evicted_address", got.evicted_address, want.evicted_address);
               if (got.evicted_dirty !== want.evicted_dirty)
                  report_mismatch("evicted_dirty", 32'(got.evicted_dirty),
                                  32'(want.evicted_dirty));
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.kind     <= sacl_pkg::KIND_LOOKUP;
      req_ch.address  <= '0;
      req_ch.time_req <= '0;
      csr_write_en    <= 1'b0;
      csr_index       <= sacl_pkg::CSR_OFFSET_BITS;
      csr_data        <= '0;
      mismatches      = 0;
      hold_request    = 1'b0;
      src_idle_pct    = 20;
      sink_stall_pct  = 20;
      geo_offs        = sacl_pkg::OFFSET_BITS_RST;
      geo_idx         = sacl_pkg::INDEX_BITS_RST;
      geo_ways        = sacl_pkg::WAY_BITS_RST;
      for (int i = 0; i < N_ENTRIES; i++) begin
         way_tag[i]   = '0;
         way_valid[i] = 1'b0;
         way_dirty[i] = 1'b0;
         way_stamp[i] = '0;
      end

      // reset geometry: tag = addr[31:14], set = addr[13:6]; set 0 gets crowded
      directed_rows = '{
         '{'{sacl_pkg::KIND_LOOKUP, 32'h0000_0000, 31'd0}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 31'h7FFF_FFFF},
           1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_FILL,   32'h0000_0000, 31'd5}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_LOOKUP, 32'h0000_003F, 31'd0}, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_DIRTY,  32'h0000_0000, 31'd0}, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_FILL,   32'h0000_4000, 31'd3}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_FILL,   32'h0000_8000, 31'd7}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_FILL,   32'h0000_C000, 31'd3}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         // full set, stamp tie: lower way goes
         '{'{sacl_pkg::KIND_FILL,   32'h0001_0000, 31'd9},
           1'b1, '{1'b0, 1'b1, 32'h4000, 1'b0}},
         '{'{sacl_pkg::KIND_TOUCH,  32'h0000_C000, 31'h7FFF_FFFF},
           1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_FILL,   32'h0001_4000, 31'd8}, 1'b1, '{1'b0, 1'b1, 32'h0, 1'b1}},
         '{'{sacl_pkg::KIND_INVAL,  32'h0000_8000, 31'd0}, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_INVAL,  32'h0000_8000, 31'd0}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_TOUCH,  32'h0000_8000, 31'd2}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_DIRTY,  32'h0000_8000, 31'd0}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_FILL,   32'hFFFF_FFC0, 31'h7FFF_FFFF},
           1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{KIND_SPARE5,           32'hFFFF_FFFF, 31'd0}, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
         '{'{KIND_SPARE6,           32'hFFFF_FFFF, 31'd0}, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
         '{'{KIND_SPARE7,           32'h0000_8000, 31'd0}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_FILL,   32'h0000_8000, 31'd0}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         // fill ignores the hit: same tag lands in a second way
         '{'{sacl_pkg::KIND_FILL,   32'h0000_C000, 31'd1},
           1'b1, '{1'b1, 1'b1, 32'h8000, 1'b0}},
         '{'{sacl_pkg::KIND_DIRTY,  32'h0000_C000, 31'd0}, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_FILL,   32'h0001_8000, 31'd2},
           1'b1, '{1'b0, 1'b1, 32'hC000, 1'b1}},
         '{'{sacl_pkg::KIND_INVAL,  32'h0000_C000, 31'd0}, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_LOOKUP, 32'h0000_C000, 31'd0}, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
         '{'{sacl_pkg::KIND_FILL,   32'h0001_C000, 31'd100}, 1'b0, '0}
      };

      // offs, index, ways, sender idle %, receiver stall %
      phase_geo = '{
         '{4'd0,  4'd0,  2'd0, 8'd30, 8'd30},
         '{4'd12, 4'd8,  2'd2, 8'd0,  8'd15},
         '{4'd15, 4'd15, 2'd3, 8'd15, 8'd0},
         '{4'd3,  4'd2,  2'd1, 8'd50, 8'd50},
         '{4'd0,  4'd8,  2'd3, 8'd10, 8'd25},
         '{4'd13, 4'd1,  2'd2, 8'd25, 8'd10},
         '{4'd6,  4'd8,  2'd2, 8'd0,  8'd0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         offer_beat(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         settle_pipeline();
         write_geometry(phase_geo[p]);
         // long receiver hold while beats keep coming, so the input backs up
         if (p == 1) hold_request = 1'b1;
         repeat (PHASE_BEATS) offer_beat(random_access(), 1'b0, '0);
      end

      settle_pipeline();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
design/sacl_pkg.sv
design/sacl_req_if.sv
design/sacl_rsp_if.sv
design/sacl_row_mem.sv
design/sacl_scan.sv
design/sacl_ctrl.sv
design/set_assoc_cache_tag_store_lru.sv
sim/tb_set_assoc_cache_tag_store_lru.sv
